/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PRDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define PRDL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/prdl_pkg.sv */
// ----------------------------------------------------------------------------
// prdl_pkg
// Types and constants of the packed rank directory lookup core.
// ----------------------------------------------------------------------------
package prdl_pkg;

  localparam int POS_W = 56;
  localparam int BLK_W = 25;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_OFFSET = 2'd1,
    REQ_FIELD  = 2'd2,
    REQ_COUNT  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_SB_BLOCKS  = 3'd0,
    CFG_FULL_BITS  = 3'd1,
    CFG_REL_BITS   = 3'd2,
    CFG_ALPHABET   = 3'd3,
    CFG_OFFSET_DIR = 3'd4,
    CFG_FIELD_AREA = 3'd5,
    CFG_COUNT_DIR  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RD_FULL  = 2'd0,
    RD_REL   = 2'd1,
    RD_FIELD = 2'd2
  } rd_kind_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_DIV   = 11'b00000000010,
    ST_M1    = 11'b00000000100,
    ST_M2    = 11'b00000001000,
    ST_M3    = 11'b00000010000,
    ST_M4    = 11'b00000100000,
    ST_M5    = 11'b00001000000,
    ST_RCHK  = 11'b00010000000,
    ST_RBYTE = 11'b00100000000,
    ST_EXT   = 11'b01000000000,
    ST_DISP  = 11'b10000000000
  } state_t;

endpackage

/* rtl/core/packed_rank_directory_lookup_core.sv */
// ----------------------------------------------------------------------------
// packed_rank_directory_lookup_core
// Byte store queried as a bit-packed two-level rank directory.
// ----------------------------------------------------------------------------
// A write beat leaves the block free. A block-offset or symbol-count query
// runs the bit-serial division of the block number by the superblock size,
// the position multiplies and a field read, plus a second field read when a
// relative sum is read; each field read fetches five bytes through the single
// read port of the byte store. A variable-field query runs two directory
// lookups and a third read. A read error ends a query early. Busy is high for
// the whole query. Each answer is shown for one cycle with out_valid high, and
// the receiver cannot stall it.
`include "assert_macros.svh"

module packed_rank_directory_lookup_core import prdl_pkg::*; #(
  parameter int STORE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [11:0] in_write_addr,
  input  logic [7:0]  in_write_byte,
  input  logic [23:0] in_block_index,
  input  logic [7:0]  in_symbol_index,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        out_error,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam logic [POS_W-1:0] BIT_LIMIT = POS_W'(STORE_BYTES) << 3;

  state_t             state_r;
  req_t               type_r;
  rd_kind_t           kind_r;
  logic [10:0]        sb_r;
  logic [5:0]         fbits_r, rbits_r;
  logic [8:0]         alpha_r;
  logic [11:0]        obase_r, fbase_r, cbase_r, base_r;
  logic [BLK_W-1:0]   blk_r, dvd_r, ps_r, pr_r;
  logic [11:0]        rem_r;
  logic [4:0]         cnt_r;
  logic [8:0]         stride_r;
  logic [7:0]         sel_r;
  logic               pass_r, err_unused;
  logic [16:0]        t1_r;
  logic [17:0]        per1_r;
  logic [30:0]        a1_r, a2_r;
  logic [26:0]        persb_r;
  logic [31:0]        a3_r;
  logic [13:0]        fsel_r, rsel_r;
  logic [51:0]        qp_r;
  logic [40:0]        rp_r;
  logic [POS_W-1:0]   rd_pos_r, relpos_r, origin;
  logic [5:0]         rd_w_r;
  logic [39:0]        acc_r, ext_sh, ext_v;
  logic [31:0]        rv_r, sum_r, lo_r, dsum, wdiff;
  logic               out_valid_r, out_error_r;
  logic [31:0]        out_value_r;
  logic [10:0]        s_eff;
  logic [11:0]        rem_sh;
  logic               accept, ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;

  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);
  assign s_eff = (sb_r == 11'd0) ? 11'd1 : sb_r;
  assign rem_sh = {rem_r[10:0], dvd_r[BLK_W-1]};
  assign origin = POS_W'(base_r) << 3;
  assign ext_sh = acc_r << rd_pos_r[2:0];
  assign ext_v = ext_sh >> (6'd40 - rd_w_r);
  assign dsum = (kind_r == RD_REL) ? (sum_r + rv_r) : rv_r;
  assign wdiff = dsum - lo_r;
  assign err_unused = 1'b0;

  assign ram_we = accept && (in_req_type == REQ_WRITE) &&
                  (32'(in_write_addr) < 32'(STORE_BYTES));
  assign ram_re = (state_r == ST_RBYTE) && (cnt_r != 5'd5);
  assign ram_raddr = rd_pos_r[3 +: ADDR_W] + ADDR_W'(cnt_r);

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

  prdl_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_write_addr)),
    .wdata (in_write_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sb_r        <= 11'd1;
      fbits_r     <= 6'd32;
      rbits_r     <= 6'd16;
      alpha_r     <= 9'd4;
      obase_r     <= 12'd0;
      fbase_r     <= 12'd0;
      cbase_r     <= 12'd0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SB_BLOCKS:  sb_r    <= cfg_wdata[10:0];
          CFG_FULL_BITS:  fbits_r <= cfg_wdata[5:0];
          CFG_REL_BITS:   rbits_r <= cfg_wdata[5:0];
          CFG_ALPHABET:   alpha_r <= cfg_wdata[8:0];
          CFG_OFFSET_DIR: obase_r <= cfg_wdata;
          CFG_FIELD_AREA: fbase_r <= cfg_wdata;
          CFG_COUNT_DIR:  cbase_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && (in_req_type != REQ_WRITE)) begin
            type_r   <= req_t'(in_req_type);
            pass_r   <= 1'b0;
            blk_r    <= {1'b0, in_block_index};
            dvd_r    <= {1'b0, in_block_index};
            rem_r    <= 12'd0;
            cnt_r    <= 5'd0;
            stride_r <= (in_req_type == REQ_COUNT) ? alpha_r : 9'd1;
            sel_r    <= (in_req_type == REQ_COUNT) ? in_symbol_index : 8'd0;
            base_r   <= (in_req_type == REQ_COUNT) ? cbase_r : obase_r;
            state_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_sh >= {1'b0, s_eff}) begin
            rem_r <= rem_sh - {1'b0, s_eff};
            dvd_r <= {dvd_r[BLK_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            dvd_r <= {dvd_r[BLK_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(BLK_W - 1)) begin
            state_r <= ST_M1;
          end
        end
        ST_M1: begin
          t1_r    <= 17'(s_eff - 11'd1) * 17'(rbits_r);
          ps_r    <= dvd_r + BLK_W'(1);
          pr_r    <= blk_r - dvd_r - BLK_W'(1);
          state_r <= ST_M2;
        end
        ST_M2: begin
          per1_r  <= 18'(fbits_r) + 18'(t1_r);
          a1_r    <= 31'(ps_r) * 31'(fbits_r);
          a2_r    <= 31'(pr_r) * 31'(rbits_r);
          state_r <= ST_M3;
        end
        ST_M3: begin
          persb_r <= 27'(per1_r) * 27'(stride_r);
          a3_r    <= 32'(a1_r) + 32'(a2_r);
          fsel_r  <= 14'(fbits_r) * 14'(sel_r);
          rsel_r  <= 14'(rbits_r) * 14'(sel_r);
          state_r <= ST_M4;
        end
        ST_M4: begin
          qp_r    <= 52'(dvd_r) * 52'(persb_r);
          rp_r    <= 41'(a3_r) * 41'(stride_r);
          state_r <= ST_M5;
        end
        ST_M5: begin
          rd_pos_r <= origin + POS_W'(qp_r) + POS_W'(fsel_r);
          relpos_r <= origin + POS_W'(rp_r) + POS_W'(rsel_r);
          rd_w_r   <= fbits_r;
          kind_r   <= RD_FULL;
          state_r  <= ST_RCHK;
        end
        ST_RCHK: begin
          if (rd_w_r > 6'd32) begin
            out_valid_r <= 1'b1;
            out_error_r <= 1'b1;
            out_value_r <= 32'd0;
            state_r     <= ST_IDLE;
          end else if (rd_w_r == 6'd0) begin
            rv_r    <= 32'd0;
            state_r <= ST_DISP;
          end else if (rd_pos_r + POS_W'(rd_w_r) > BIT_LIMIT) begin
            out_valid_r <= 1'b1;
            out_error_r <= 1'b1;
            out_value_r <= 32'd0;
            state_r     <= ST_IDLE;
          end else begin
            cnt_r   <= 5'd0;
            state_r <= ST_RBYTE;
          end
        end
        ST_RBYTE: begin
          if (cnt_r != 5'd0) begin
            acc_r <= {acc_r[31:0], ram_rdata};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd5) begin
            state_r <= ST_EXT;
          end
        end
        ST_EXT: begin
          rv_r    <= ext_v[31:0];
          state_r <= ST_DISP;
        end
        ST_DISP: begin
          if (kind_r == RD_FIELD) begin
            out_valid_r <= 1'b1;
            out_error_r <= err_unused;
            out_value_r <= rv_r;
            state_r     <= ST_IDLE;
          end else if ((kind_r == RD_FULL) && (rem_r != 12'd0)) begin
            sum_r    <= rv_r;
            rd_pos_r <= relpos_r;
            rd_w_r   <= rbits_r;
            kind_r   <= RD_REL;
            state_r  <= ST_RCHK;
          end else if (type_r != REQ_FIELD) begin
            out_valid_r <= 1'b1;
            out_error_r <= 1'b0;
            out_value_r <= dsum;
            state_r     <= ST_IDLE;
          end else if (!pass_r) begin
            lo_r    <= dsum;
            pass_r  <= 1'b1;
            blk_r   <= blk_r + BLK_W'(1);
            dvd_r   <= blk_r + BLK_W'(1);
            rem_r   <= 12'd0;
            cnt_r   <= 5'd0;
            state_r <= ST_DIV;
          end else if (wdiff > 32'd32) begin
            out_valid_r <= 1'b1;
            out_error_r <= 1'b1;
            out_value_r <= 32'd0;
            state_r     <= ST_IDLE;
          end else begin
            rd_pos_r <= (POS_W'(fbase_r) << 3) + POS_W'(lo_r);
            rd_w_r   <= wdiff[5:0];
            kind_r   <= RD_FIELD;
            state_r  <= ST_RCHK;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `PRDL_ASSERT(a_single_beat, out_valid |=> !out_valid, "result beat longer than one cycle")
  `PRDL_ASSERT(a_err_zero, out_valid && out_error |-> out_value == 32'd0, "error beat with value")
  `PRDL_ASSERT(a_query_busy, start && !busy && in_req_type != REQ_WRITE |=> busy, "query not taken")
  `PRDL_NEVER(a_write_idle, ram_we && busy, "store written during a query")

endmodule

/* rtl/core/prdl_ram.sv */
// ----------------------------------------------------------------------------
// prdl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module prdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
